FILE: src/session_id_table_macros.svh
// ----------------------------------------------------------------------------
// session_id_table_macros.svh
// Assertion macros shared by the session identifier table.
// ----------------------------------------------------------------------------
`ifndef SESSION_ID_TABLE_MACROS_SVH
`define SESSION_ID_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Sizes, request codes and status codes of the session identifier table.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int SESSIONS = 4;
  localparam int SLOT_W   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  localparam int ID_W     = 32;
  localparam int HALF_W   = 16;

  localparam logic [ID_W-1:0]   ID_INVALID = 32'h0000_0000;
  localparam logic [ID_W-1:0]   MASK_FULL  = 32'hFFFF_FFFF;
  localparam logic [ID_W-1:0]   MASK_UPPER = 32'hFFFF_0000;
  localparam logic [ID_W-1:0]   MASK_LOWER = 32'h0000_FFFF;
  localparam logic [HALF_W-1:0] HALF_TOP   = 16'hFFFF;

  // Request codes
  localparam logic [2:0] FN_LOOKUP    = 3'd0;
  localparam logic [2:0] FN_ASSIGN    = 3'd1;
  localparam logic [2:0] FN_FREE      = 3'd2;
  localparam logic [2:0] FN_ALLOC_REQ = 3'd3;
  localparam logic [2:0] FN_ALLOC_RSP = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_DUP     = 2'd2;
  localparam logic [1:0] STAT_MISS    = 2'd3;

endpackage

FILE: src/session_id_table.sv
// ----------------------------------------------------------------------------
// session_id_table
// Small table of session identifiers with a pre-shared-key flag per slot.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// shows on the out_ ports for exactly one cycle, marked by out_valid, and
// must be captured then since the receiver cannot hold it off. One shared
// masked compare unit visits one slot per cycle under a small sequencer, so
// the cost of an item follows the slot scan: an invalid identifier or an
// unused request code is answered without a scan; lookup, free and half
// allocation stop at the first matching slot or after the last one; and
// assign scans once for a duplicate and once more for a free slot. busy
// is high while the scan runs and drops in the cycle the result shows, so
// the next item may be started alongside the strobe. The table clears to
// invalid at reset.
// ----------------------------------------------------------------------------
`include "session_id_table_macros.svh"

module session_id_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_func,
  input  logic [sit_pkg::ID_W-1:0]  in_session_id,
  input  logic                      in_use_psk,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [1:0]                out_slot,
  output logic [sit_pkg::HALF_W-1:0] out_half_id,
  output logic                      out_slot_psk
);
  import sit_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_SCAN = 1'b1;

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SESSIONS - 1);

  // Table storage, cleared at reset
  logic [ID_W-1:0] ids_r   [SESSIONS];
  logic            psk_r   [SESSIONS];
  logic [ID_W-1:0] latest_id_r;

  // Sequencer
  logic [0:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              pass_r, pass_nxt;     // second assign pass: free search
  logic [2:0]        func_r, func_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              use_psk_r, use_psk_nxt;
  logic [ID_W-1:0]   mask_r, mask_nxt;
  logic [ID_W-1:0]   key_r, key_nxt;

  // Result registers
  logic              valid_r, valid_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [HALF_W-1:0] half_r, half_nxt;
  logic              spsk_r, spsk_nxt;

  // Table write port
  logic              wr_en;
  logic [ID_W-1:0]   wr_id;
  logic              wr_psk;
  logic              latest_we;

  logic accept;
  logic hit;
  logic at_last;

  assign accept  = start && (state_r == S_IDLE);
  // Shared compare unit: masked slot identifier against the search key
  assign hit     = ((ids_r[idx_r] & mask_r) == key_r);
  assign at_last = (idx_r == LAST_IDX);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    pass_nxt    = pass_r;
    func_nxt    = func_r;
    id_nxt      = id_r;
    use_psk_nxt = use_psk_r;
    mask_nxt    = mask_r;
    key_nxt     = key_r;
    valid_nxt   = 1'b0;
    status_nxt  = status_r;
    slot_nxt    = slot_r;
    half_nxt    = half_r;
    spsk_nxt    = spsk_r;
    wr_en       = 1'b0;
    wr_id       = ID_INVALID;
    wr_psk      = 1'b0;
    latest_we   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt    = in_func;
          id_nxt      = in_session_id;
          use_psk_nxt = in_use_psk;
          idx_nxt     = '0;
          pass_nxt    = 1'b0;
          key_nxt     = ID_INVALID;
          mask_nxt    = MASK_FULL;
          status_nxt  = STAT_MISS;
          slot_nxt    = 2'd0;
          half_nxt    = '0;
          spsk_nxt    = 1'b0;
          case (in_func) inside
            FN_LOOKUP, FN_ASSIGN, FN_FREE: begin
              if (in_session_id == ID_INVALID) begin
                // Invalid identifier: answer at once, touch nothing
                valid_nxt  = 1'b1;
                status_nxt = STAT_INVALID;
              end else begin
                key_nxt   = in_session_id;
                state_nxt = S_SCAN;
              end
            end
            FN_ALLOC_REQ: begin
              mask_nxt  = MASK_UPPER;
              state_nxt = S_SCAN;
            end
            FN_ALLOC_RSP: begin
              mask_nxt  = MASK_LOWER;
              state_nxt = S_SCAN;
            end
            default: begin
              // Unused request code: report a miss
              valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          state_nxt  = S_IDLE;
          valid_nxt  = 1'b1;
          status_nxt = STAT_OK;
          slot_nxt   = 2'(idx_r);
          case (func_r) inside
            FN_LOOKUP: begin
              spsk_nxt = psk_r[idx_r];
            end
            FN_ASSIGN: begin
              if (!pass_r) begin
                // Identifier already present
                status_nxt = STAT_DUP;
                slot_nxt   = 2'd0;
              end else begin
                wr_en     = 1'b1;
                wr_id     = id_r;
                wr_psk    = use_psk_r;
                latest_we = 1'b1;
              end
            end
            FN_FREE: begin
              wr_en = 1'b1;
            end
            default: begin
              half_nxt = HALF_TOP - HALF_W'(idx_r);
            end
          endcase
        end else if (at_last) begin
          if ((func_r == FN_ASSIGN) && !pass_r) begin
            // No duplicate: rescan for the first free slot
            pass_nxt = 1'b1;
            idx_nxt  = '0;
            key_nxt  = ID_INVALID;
          end else begin
            state_nxt = S_IDLE;
            valid_nxt = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= 1'b0;
      latest_id_r <= ID_INVALID;
      for (int i = 0; i < SESSIONS; i++) begin
        ids_r[i] <= ID_INVALID;
        psk_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (wr_en) begin
        ids_r[idx_r] <= wr_id;
        psk_r[idx_r] <= wr_psk;
      end
      if (latest_we) begin
        latest_id_r <= id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    pass_r    <= pass_nxt;
    func_r    <= func_nxt;
    id_r      <= id_nxt;
    use_psk_r <= use_psk_nxt;
    mask_r    <= mask_nxt;
    key_r     <= key_nxt;
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
    half_r    <= half_nxt;
    spsk_r    <= spsk_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = valid_r;
  assign out_status   = status_r;
  assign out_slot     = slot_r;
  assign out_half_id  = half_r;
  assign out_slot_psk = spsk_r;

  // Checks
  `SIT_ASSERT_NOW(a_strobe_not_busy, out_valid, !busy, "result shown while scanning")
  `SIT_ASSERT_NEXT(a_accept_progress, accept, busy || out_valid, "accepted item dropped")
  `SIT_ASSERT_NOW(a_fail_clean, out_valid && (out_status != STAT_OK), (out_slot == 2'd0) && (out_half_id == '0) && !out_slot_psk, "failed result carries data")
  `SIT_ASSERT_NOW(a_latest_follows, out_valid && (func_r == FN_ASSIGN) && (out_status == STAT_OK), latest_id_r == id_r, "latest identifier not recorded")
endmodule

FILE: tb/sv/session_id_table_checker.sv
// ----------------------------------------------------------------------------
// session_id_table_checker
// Watches both channels of the session identifier table, predicts each
// result from its own copy of the slots and compares it field by field.
// ----------------------------------------------------------------------------
module session_id_table_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [2:0]                 in_func,
  input  logic [sit_pkg::ID_W-1:0]   in_session_id,
  input  logic                       in_use_psk,
  input  logic                       out_valid,
  input  logic [1:0]                 out_status,
  input  logic [1:0]                 out_slot,
  input  logic [sit_pkg::HALF_W-1:0] out_half_id,
  input  logic                       out_slot_psk,
  output int                         fail_count,
  output int                         pending_results
);
  import sit_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        slot;
    logic [HALF_W-1:0] half_id;
    logic              slot_psk;
  } table_answer_t;

  logic [ID_W-1:0] id_store [SESSIONS];
  logic            psk_store [SESSIONS];
  logic [ID_W-1:0] last_assigned_id;
  table_answer_t   expected_answers [$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  // First slot whose masked identifier equals value, or -1.
  function automatic int first_slot(input logic [ID_W-1:0] mask,
                                    input logic [ID_W-1:0] value);
    int hit;
    hit = -1;
    for (int i = SESSIONS - 1; i >= 0; i--) begin
      if ((id_store[i] & mask) == value) hit = i;
    end
    return hit;
  endfunction

  // Serve one request against the local table and return its answer.
  function automatic table_answer_t serve_request(input logic [2:0]      fn,
                                                  input logic [ID_W-1:0] id,
                                                  input logic            psk);
    table_answer_t ans;
    int            idx;
    ans        = '0;
    ans.status = STAT_MISS;
    case (fn) inside
      FN_LOOKUP, FN_ASSIGN, FN_FREE: begin
        if (id == ID_INVALID) begin
          ans.status = STAT_INVALID;
        end else begin
          idx = first_slot(MASK_FULL, id);
          if (fn == FN_LOOKUP) begin
            if (idx >= 0) begin
              ans.status   = STAT_OK;
              ans.slot     = idx[1:0];
              ans.slot_psk = psk_store[idx];
            end
          end else if (fn == FN_ASSIGN) begin
            if (idx >= 0) begin
              ans.status = STAT_DUP;
            end else begin
              idx = first_slot(MASK_FULL, ID_INVALID);
              if (idx >= 0) begin
                id_store[idx]    = id;
                psk_store[idx]   = psk;
                last_assigned_id = id;
                ans.status       = STAT_OK;
                ans.slot         = idx[1:0];
              end
            end
          end else if (idx >= 0) begin
            id_store[idx]  = ID_INVALID;
            psk_store[idx] = 1'b0;
            ans.status     = STAT_OK;
            ans.slot       = idx[1:0];
          end
        end
      end
      FN_ALLOC_REQ, FN_ALLOC_RSP: begin
        idx = first_slot((fn == FN_ALLOC_REQ) ? MASK_UPPER : MASK_LOWER, ID_INVALID);
        if (idx >= 0) begin
          ans.status  = STAT_OK;
          ans.slot    = idx[1:0];
          ans.half_id = HALF_TOP - idx[HALF_W-1:0];
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    table_answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < SESSIONS; i++) begin
        id_store[i]  = ID_INVALID;
        psk_store[i] = 1'b0;
      end
      last_assigned_id = ID_INVALID;
      expected_answers.delete();
    end else begin
      // Retire the oldest answer before taking the item started alongside it.
      if (out_valid) begin
        if (expected_answers.size() == 0) begin
          $error("result with none expected: status %0d slot %0d half_id 0x%0h",
                 out_status, out_slot, out_half_id);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          check_field("out_status",   32'(want.status),   32'(out_status));
          check_field("out_slot",     32'(want.slot),     32'(out_slot));
          check_field("out_half_id",  32'(want.half_id),  32'(out_half_id));
          check_field("out_slot_psk", 32'(want.slot_psk), 32'(out_slot_psk));
        end
      end
      if (start && !busy) begin
        expected_answers.push_back(serve_request(in_func, in_session_id, in_use_psk));
      end
    end
    pending_results <= expected_answers.size();
  end

endmodule

FILE: tb/sv/tb_session_id_table.sv
// ----------------------------------------------------------------------------
// tb_session_id_table
// Drives requests into the session identifier table and gives the verdict.
// ----------------------------------------------------------------------------
// A short directed run walks the invalid identifier, duplicates, a full
// table, lookups with and without the key flag, frees that hit and miss,
// half allocation with and without a free half, and the spare request codes.
// Random requests follow in three phases of sender idling (none, heavy,
// light). They draw most identifiers from a small pool so that lookups,
// frees and duplicates hit, and mix in fresh ones shaped to leave one half
// zero. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_session_id_table;
  import sit_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 2 * SESSIONS + 12;
  localparam int PHASE_ITEMS  = 500;
  localparam int POOL_SIZE    = 8;

  // Request codes the block leaves unused.
  localparam logic [2:0] FN_SPARE_LO  = 3'd5;
  localparam logic [2:0] FN_SPARE_MID = 3'd6;
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                start         = 1'b0;
  logic [2:0]          in_func       = FN_LOOKUP;
  logic [ID_W-1:0]     in_session_id = ID_INVALID;
  logic                in_use_psk    = 1'b0;
  logic                busy;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [1:0]          out_slot;
  logic [HALF_W-1:0]   out_half_id;
  logic                out_slot_psk;
  int                  fail_count;
  int                  pending_results;

  int                  sender_idle_pct = 0;
  logic [ID_W-1:0]     id_pool [POOL_SIZE];

  always #4 clk = ~clk;

  session_id_table dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_session_id (in_session_id),
    .in_use_psk    (in_use_psk),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_half_id   (out_half_id),
    .out_slot_psk  (out_slot_psk)
  );

  session_id_table_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_session_id   (in_session_id),
    .in_use_psk      (in_use_psk),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_half_id     (out_half_id),
    .out_slot_psk    (out_slot_psk),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // Offer one item and hold it until the block takes it. Called right after
  // a rising edge; returns right after the edge that accepted the item, so
  // a follow-on item with no gap keeps start high without a dip.
  task automatic offer_item(input logic [2:0] fn, input logic [ID_W-1:0] id,
                            input logic psk);
    // Idle the sender cycle by cycle at the phase's rate, so the next start
    // lands on every step of the slot scan.
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_func       <= fn;
    in_session_id <= id;
    in_use_psk    <= psk;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Make a fresh identifier: plain random, one half zero, or an extreme.
  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] id;
    case ($urandom_range(9))
      0, 1:    id = {16'h0000, 16'($urandom_range(1, 16'hFFFF))};
      2, 3:    id = {16'($urandom_range(1, 16'hFFFF)), 16'h0000};
      4: begin
        case ($urandom_range(3))
          0:       id = MASK_FULL;
          1:       id = 32'h0000_0001;
          2:       id = 32'h8000_0000;
          default: id = MASK_UPPER;
        endcase
      end
      default: id = $urandom;
    endcase
    // Keep the invalid identifier out of the pool; it is drawn on purpose.
    if (id == ID_INVALID) id = 32'h0000_0001;
    return id;
  endfunction

  // Hang guard: end the run if the handshakes stop moving.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_session_id_table: errors");
    $finish;
  end

  initial begin : stimulus
    logic [2:0]      fn;
    logic [ID_W-1:0] id;
    int              pick;
    int              sent;

    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = fresh_id();

    // Hold reset, then release it.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: the invalid identifier on every request that takes one.
    offer_item(FN_LOOKUP,    ID_INVALID,   1'b1);
    offer_item(FN_ASSIGN,    ID_INVALID,   1'b1);
    offer_item(FN_FREE,      ID_INVALID,   1'b0);
    // Half allocation on an empty table hits slot zero.
    offer_item(FN_ALLOC_REQ, ID_INVALID,   1'b0);
    offer_item(FN_ALLOC_RSP, MASK_FULL,    1'b1);
    // Lookup and free on an empty table miss.
    offer_item(FN_LOOKUP,    MASK_FULL,    1'b0);
    offer_item(FN_FREE,      MASK_FULL,    1'b0);
    // Fill the table with extreme identifiers; try a duplicate and overflow.
    offer_item(FN_ASSIGN,    MASK_FULL,    1'b1);
    offer_item(FN_ASSIGN,    MASK_LOWER,   1'b0);
    offer_item(FN_ASSIGN,    MASK_UPPER,   1'b1);
    offer_item(FN_ASSIGN,    MASK_FULL,    1'b0);
    offer_item(FN_ASSIGN,    32'h8000_0001, 1'b0);
    offer_item(FN_ASSIGN,    32'h1234_5678, 1'b1);
    // Lookups return the stored key flag.
    offer_item(FN_LOOKUP,    MASK_FULL,    1'b0);
    offer_item(FN_LOOKUP,    MASK_LOWER,   1'b1);
    // Halves free in a full table: upper in slot one, lower in slot two.
    offer_item(FN_ALLOC_REQ, ID_INVALID,   1'b0);
    offer_item(FN_ALLOC_RSP, ID_INVALID,   1'b0);
    // Free a slot and refill it so that no upper half is free any more.
    offer_item(FN_FREE,      MASK_LOWER,   1'b0);
    offer_item(FN_ASSIGN,    32'h0001_0000, 1'b1);
    offer_item(FN_ALLOC_REQ, MASK_FULL,    1'b1);
    // A partial match must not count as a hit.
    offer_item(FN_LOOKUP,    32'h0000_0001, 1'b0);
    // Spare request codes are answered as misses.
    offer_item(FN_SPARE_LO,  MASK_FULL,    1'b1);
    offer_item(FN_SPARE_MID, 32'h0000_0001, 1'b0);
    offer_item(FN_SPARE_HI,  ID_INVALID,   1'b1);

    // Random part, one phase per sender idling level.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 74;
        default: sender_idle_pct = 12;
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 30)      fn = FN_ASSIGN;
        else if (pick < 55) fn = FN_FREE;
        else if (pick < 73) fn = FN_LOOKUP;
        else if (pick < 84) fn = FN_ALLOC_REQ;
        else if (pick < 95) fn = FN_ALLOC_RSP;
        else                fn = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));

        // Draw mostly from the pool so that hits and duplicates happen.
        pick = $urandom_range(99);
        if (pick < 4)       id = ID_INVALID;
        else if (pick < 82) id = id_pool[$urandom_range(POOL_SIZE - 1)];
        else                id = fresh_id();

        // Refresh the pool now and then so the live set drifts.
        if ($urandom_range(99) < 6) id_pool[$urandom_range(POOL_SIZE - 1)] = fresh_id();

        offer_item(fn, id, 1'($urandom_range(1)));
        // Spare codes are only noise; do not count them.
        if (fn <= FN_ALLOC_RSP) sent++;
      end
    end

    // Drop start, let the last result arrive, then give the verdict.
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_session_id_table: clean");
    end else begin
      $display("tb_session_id_table: errors");
    end
    $finish;
  end

endmodule
